// ===== src/cbt_pkg.sv =====
// Shared types and constants for the cubic Bezier tessellator.
// No dependencies; every other file in src/ uses this package.
package cbt_pkg;

   localparam int COORD_W     = 32;
   localparam int T_W         = 17;
   localparam int TINC_W      = 16;
   localparam int STEPS_CFG_W = 7;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int DEF_MAX_STEPS = 64;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [T_W-1:0] T_ONE = 17'h1_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_IDX = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TINC_IDX  = 4'd1;

   localparam logic [STEPS_CFG_W-1:0] STEPS_RESET = 7'd16;
   localparam logic [TINC_W-1:0]      TINC_RESET  = 16'd4096;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      point_type p0;
      point_type p1;
      point_type p2;
      point_type p3;
   } segment_type;

endpackage

// ===== src/cbt_req_if.sv =====
// Control point channel: valid/ready plus one 3D control point.
// Depends on cbt_pkg.
interface cbt_req_if;
   logic                valid;
   logic                ready;
   cbt_pkg::coord_type  ctrl_x;
   cbt_pkg::coord_type  ctrl_y;
   cbt_pkg::coord_type  ctrl_z;
   logic                start_curve;

   modport source (output valid, ctrl_x, ctrl_y, ctrl_z, start_curve, input ready);
   modport sink   (input valid, ctrl_x, ctrl_y, ctrl_z, start_curve, output ready);
endinterface

// ===== src/cbt_rsp_if.sv =====
// Curve point channel: valid/ready plus one evaluated point and its flag.
// Depends on cbt_pkg.
interface cbt_rsp_if;
   logic                valid;
   logic                ready;
   cbt_pkg::coord_type  curve_x;
   cbt_pkg::coord_type  curve_y;
   cbt_pkg::coord_type  curve_z;
   logic                last_of_segment;

   modport source (output valid, curve_x, curve_y, curve_z, last_of_segment, input ready);
   modport sink   (input valid, curve_x, curve_y, curve_z, last_of_segment, output ready);
endinterface

// ===== src/cbt_csr_if.sv =====
// Register write channel: valid/ready, register index and write data.
// Depends on cbt_pkg.
interface cbt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cbt_pkg::CSR_IDX_W-1:0]      index;
   logic [cbt_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/cbt_front.sv =====
// Front end: takes control point beats, holds the open segment's points and
// queues each completed segment if emit_en. Depends on cbt_pkg, cbt_req_if.
module cbt_front (
   input  logic                clock,
   input  logic                reset,
   cbt_req_if.sink             req,
   input  logic                emit_en,   // current step count is nonzero
   input  logic                q_ready,
   output logic                q_push,
   output cbt_pkg::segment_type q_seg
);

   cbt_pkg::point_type p_ff [3];
   logic [1:0]         held_ff;
   logic [1:0]         held_in;
   logic [1:0]         held_eff;
   logic               accept;
   cbt_pkg::point_type new_pt;

   assign req.ready = q_ready;
   assign accept    = req.valid && req.ready;
   assign new_pt    = '{x: req.ctrl_x, y: req.ctrl_y, z: req.ctrl_z};
   assign held_eff  = req.start_curve ? 2'd0 : held_ff;

   assign q_seg  = '{p0: p_ff[0], p1: p_ff[1], p2: p_ff[2], p3: new_pt};
   assign q_push = accept && (held_eff == 2'd3) && emit_en;

   // fourth point closes a segment; its end point opens the next one
   assign held_in = (held_eff == 2'd3) ? 2'd1 : held_eff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
      end else if (accept) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         unique case (held_eff)
            2'd0: p_ff[0] <= new_pt;
            2'd1: p_ff[1] <= new_pt;
            2'd2: p_ff[2] <= new_pt;
            2'd3: p_ff[0] <= new_pt;
            default: p_ff[0] <= new_pt;
         endcase
      end
   end

   a_held_nonzero: assert property (@(posedge clock) disable iff (reset)
      accept |=> held_ff != 2'd0)
      else $error("point count zero after a control point beat");

endmodule

// ===== src/cbt_seg_queue.sv =====
// Short FIFO of completed segments between front and back ends.
// Depends on cbt_pkg.
module cbt_seg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cbt_pkg::segment_type push_seg,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 head_valid,
   output cbt_pkg::segment_type head_seg
);

   localparam int DEPTH = cbt_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cbt_pkg::segment_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_seg   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_seg;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("segment pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("segment popped from empty queue");

endmodule

// ===== src/cbt_eval.sv =====
// Back end: steps t across the queued segment and runs a three-level
// de Casteljau pipeline, one curve point per beat. Depends on cbt_pkg, cbt_rsp_if.
module cbt_eval #(
   parameter int MAX_STEPS = cbt_pkg::DEF_MAX_STEPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(MAX_STEPS+1)-1:0]    steps,
   input  logic [cbt_pkg::TINC_W-1:0]        t_inc,
   input  logic                              q_valid,
   input  cbt_pkg::segment_type              q_seg,
   output logic                              q_pop,
   cbt_rsp_if.source                         rsp
);

   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int TW     = cbt_pkg::T_W;

   // a + floor((b - a) * t / 2^16); result stays between a and b
   function automatic cbt_pkg::coord_type lerp(input cbt_pkg::coord_type a,
                                               input cbt_pkg::coord_type b,
                                               input logic [TW-1:0] t);
      logic signed [32:0] diff;
      logic signed [50:0] prod;
      logic signed [32:0] sum;
      diff = $signed({b[31], b}) - $signed({a[31], a});
      prod = diff * $signed({1'b0, t});
      sum  = $signed({a[31], a}) + $signed(prod[48:16]);
      return sum[31:0];
   endfunction

   logic              adv, issue, last_issue;
   logic [STEP_W-1:0] j_ff;
   logic [TW-1:0]     t_ff, t_next;
   logic [TW:0]       t_sum;

   cbt_pkg::coord_type p0 [3], p1 [3], p2 [3], p3 [3];
   cbt_pkg::coord_type s1_a_ff [3], s1_b_ff [3], s1_d_ff [3];
   cbt_pkg::coord_type s2_e_ff [3], s2_f_ff [3];
   cbt_pkg::coord_type out_ff [3];
   logic [TW-1:0]     s1_t_ff, s2_t_ff;
   logic              s1_last_ff, s2_last_ff, out_last_ff;
   logic              s1_valid_ff, s2_valid_ff, out_valid_ff;

   assign p0 = '{q_seg.p0.x, q_seg.p0.y, q_seg.p0.z};
   assign p1 = '{q_seg.p1.x, q_seg.p1.y, q_seg.p1.z};
   assign p2 = '{q_seg.p2.x, q_seg.p2.y, q_seg.p2.z};
   assign p3 = '{q_seg.p3.x, q_seg.p3.y, q_seg.p3.z};

   // whole pipeline moves together when the output register can take a beat
   assign adv        = !out_valid_ff || rsp.ready;
   assign issue      = q_valid && adv;
   assign last_issue = (j_ff + 1'b1) == steps;
   assign q_pop      = issue && last_issue;

   // t saturates at one
   assign t_sum  = {1'b0, t_ff} + {2'b0, t_inc};
   assign t_next = (t_sum > {1'b0, cbt_pkg::T_ONE}) ? cbt_pkg::T_ONE : t_sum[TW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
         t_ff <= '0;
      end else if (issue) begin
         if (last_issue) begin
            j_ff <= '0;
            t_ff <= '0;
         end else begin
            j_ff <= j_ff + 1'b1;
            t_ff <= t_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_t_ff     <= t_ff;
         s1_last_ff  <= last_issue;
         s2_t_ff     <= s1_t_ff;
         s2_last_ff  <= s1_last_ff;
         out_last_ff <= s2_last_ff;
         for (int c = 0; c < 3; c++) begin
            s1_a_ff[c] <= lerp(p0[c], p1[c], t_ff);
            s1_b_ff[c] <= lerp(p1[c], p2[c], t_ff);
            s1_d_ff[c] <= lerp(p2[c], p3[c], t_ff);
            s2_e_ff[c] <= lerp(s1_a_ff[c], s1_b_ff[c], s1_t_ff);
            s2_f_ff[c] <= lerp(s1_b_ff[c], s1_d_ff[c], s1_t_ff);
            out_ff[c]  <= lerp(s2_e_ff[c], s2_f_ff[c], s2_t_ff);
         end
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.curve_x         = out_ff[0];
   assign rsp.curve_y         = out_ff[1];
   assign rsp.curve_z         = out_ff[2];
   assign rsp.last_of_segment = out_last_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> j_ff < steps)
      else $error("step index past step count with a segment pending");

   a_t_in_range: assert property (@(posedge clock) disable iff (reset)
      t_ff <= cbt_pkg::T_ONE)
      else $error("parameter t above one");

endmodule

// ===== src/cubic_bezier_tessellator.sv =====
// Cubic Bezier tessellator. Control points arrive one beat at a time on
// req_ch; the fourth point of a curve, and every third point after it,
// closes a cubic segment (segments share end points), and the block then
// sends steps_per_segment curve points on rsp_ch, evaluated at t = 0, dt,
// 2dt, ... (t saturating at 1.0), the final one flagged last_of_segment.
// A control point beat is taken every cycle while the two-entry segment
// queue has room; the back end produces one curve point per cycle while
// rsp_ch is ready, so a segment occupies it for steps_per_segment curve
// points and the sustained rate of control points is set by that
// evaluation pipeline. The first curve point follows the closing control
// point through the queue and the three de Casteljau levels. Registers
// (csr_ch): index 0 steps_per_segment (7 bits, clamped to MAX_STEPS, zero
// emits nothing), index 1 t_increment (Q0.16); write only while idle.
// Coordinates are signed Q16.16; the coordinate arithmetic needs no saturation.
// Depends on cbt_pkg, the three channel interfaces and the cbt_ submodules.
module cubic_bezier_tessellator #(
   parameter int MAX_STEPS = cbt_pkg::DEF_MAX_STEPS
) (
   input  logic       clock,
   input  logic       reset,
   cbt_req_if.sink    req_ch,
   cbt_rsp_if.source  rsp_ch,
   cbt_csr_if.sink    csr_ch
);

   localparam int STEP_W = $clog2(MAX_STEPS + 1);

   // configuration registers
   logic [cbt_pkg::STEPS_CFG_W-1:0] steps_ff, steps_in;
   logic [cbt_pkg::TINC_W-1:0]      tinc_ff, tinc_in;
   logic [STEP_W-1:0]               steps_eff;
   logic                            csr_wr;

   // front to queue, queue to back
   logic                 q_push, q_ready, q_pop, q_valid;
   cbt_pkg::segment_type push_seg, head_seg;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   always_comb begin
      steps_in = steps_ff;
      tinc_in  = tinc_ff;
      if (csr_wr && csr_ch.index == cbt_pkg::CSR_STEPS_IDX) begin
         steps_in = csr_ch.data[cbt_pkg::STEPS_CFG_W-1:0];
      end
      if (csr_wr && csr_ch.index == cbt_pkg::CSR_TINC_IDX) begin
         tinc_in = csr_ch.data[cbt_pkg::TINC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= cbt_pkg::STEPS_RESET;
         tinc_ff  <= cbt_pkg::TINC_RESET;
      end else begin
         steps_ff <= steps_in;
         tinc_ff  <= tinc_in;
      end
   end

   // step count limited to what the back end counter is sized for
   assign steps_eff = (steps_ff > cbt_pkg::STEPS_CFG_W'(MAX_STEPS)) ?
                      STEP_W'(MAX_STEPS) : STEP_W'(steps_ff);

   cbt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .emit_en (steps_eff != '0),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_seg   (push_seg)
   );

   cbt_seg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_seg   (push_seg),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_seg   (head_seg)
   );

   cbt_eval #(
      .MAX_STEPS (MAX_STEPS)
   ) u_eval (
      .clock   (clock),
      .reset   (reset),
      .steps   (steps_eff),
      .t_inc   (tinc_ff),
      .q_valid (q_valid),
      .q_seg   (head_seg),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

// ===== dv/cbt_checker.sv =====
// Scoreboard for the cubic Bezier tessellator: predicts curve point beats from
// observed control point and register beats and compares them in order.
// Depends on cbt_pkg and the cbt_req_if, cbt_rsp_if and cbt_csr_if interfaces.
module cbt_checker #(
   parameter int MAX_STEPS = cbt_pkg::DEF_MAX_STEPS
) (
   input  logic clock,
   input  logic reset,
   cbt_req_if   req_ch,
   cbt_rsp_if   rsp_ch,
   cbt_csr_if   csr_ch,
   output int   mismatch_count,
   output int   points_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import cbt_pkg::*;

   typedef struct packed {
      point_type pt;
      logic      last;
   } curve_beat_type;

   logic [STEPS_CFG_W-1:0] steps_cfg;
   logic [TINC_W-1:0]      t_step;
   point_type              ctrl_pts [4];
   int unsigned            held;
   curve_beat_type         curve_q [$];
   int                     errors;

   // a + floor((b - a) * t / 2^16); the arithmetic shift floors negatives
   function automatic coord_type mix(coord_type a, coord_type b, logic [T_W-1:0] t);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'(t);
      return coord_type'(longint'(a) + (prod >>> 16));
   endfunction

   function automatic coord_type bezier_coord(coord_type p0, coord_type p1, coord_type p2,
                                              coord_type p3, logic [T_W-1:0] t);
      coord_type a, b, d;
      a = mix(p0, p1, t);
      b = mix(p1, p2, t);
      d = mix(p2, p3, t);
      return mix(mix(a, b, t), mix(b, d, t), t);
   endfunction

   function automatic point_type curve_point(logic [T_W-1:0] t);
      point_type p;
      p.x = bezier_coord(ctrl_pts[0].x, ctrl_pts[1].x, ctrl_pts[2].x, ctrl_pts[3].x, t);
      p.y = bezier_coord(ctrl_pts[0].y, ctrl_pts[1].y, ctrl_pts[2].y, ctrl_pts[3].y, t);
      p.z = bezier_coord(ctrl_pts[0].z, ctrl_pts[1].z, ctrl_pts[2].z, ctrl_pts[3].z, t);
      return p;
   endfunction

   always @(posedge clock) begin
      int unsigned    slot, n, tt;
      logic [T_W-1:0] t;
      curve_beat_type exp_beat;
      curve_beat_type next_beat;
      if (reset) begin
         steps_cfg = STEPS_RESET;
         t_step    = TINC_RESET;
         held      = 0;
         errors    = 0;
         curve_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_STEPS_IDX) begin
               steps_cfg = csr_ch.data[STEPS_CFG_W-1:0];
            end else if (csr_ch.index == CSR_TINC_IDX) begin
               t_step = csr_ch.data[TINC_W-1:0];
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.start_curve) begin
               held = 0;
            end
            slot = (held >= 4) ? 3 : held;
            ctrl_pts[slot] = '{x: req_ch.ctrl_x, y: req_ch.ctrl_y, z: req_ch.ctrl_z};
            held = slot + 1;
            if (held == 4) begin
               n = (steps_cfg > MAX_STEPS) ? MAX_STEPS : steps_cfg;
               for (int unsigned j = 0; j < n; j++) begin
                  tt = j * t_step;
                  t  = (tt > T_ONE) ? T_ONE : T_W'(tt);
                  next_beat.pt   = curve_point(t);
                  next_beat.last = (j + 1 == n);
                  curve_q = {curve_q, next_beat};
               end
               // end point carries over as the next segment's start
               ctrl_pts[0] = ctrl_pts[3];
               held = 1;
            end
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (curve_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected curve beat x %h y %h z %h last %b", $time,
                        rsp_ch.curve_x, rsp_ch.curve_y, rsp_ch.curve_z,
                        rsp_ch.last_of_segment);
            end else begin
               exp_beat = curve_q.pop_front();
               if (rsp_ch.curve_x !== exp_beat.pt.x) begin
                  errors++;
                  $display("%0t: curve_x expected %h actual %h", $time,
                           exp_beat.pt.x, rsp_ch.curve_x);
               end
               if (rsp_ch.curve_y !== exp_beat.pt.y) begin
                  errors++;
                  $display("%0t: curve_y expected %h actual %h", $time,
                           exp_beat.pt.y, rsp_ch.curve_y);
               end
               if (rsp_ch.curve_z !== exp_beat.pt.z) begin
                  errors++;
                  $display("%0t: curve_z expected %h actual %h", $time,
                           exp_beat.pt.z, rsp_ch.curve_z);
               end
               if (rsp_ch.last_of_segment !== exp_beat.last) begin
                  errors++;
                  $display("%0t: last_of_segment expected %b actual %b", $time,
                           exp_beat.last, rsp_ch.last_of_segment);
               end
            end
         end
      end
      mismatch_count <= errors;
      points_pending <= curve_q.size();
   end

endmodule

// ===== dv/cubic_bezier_tessellator_test.sv =====
// Top of the tessellator testbench: clock, reset, control point and register
// stimulus, receiver back-pressure and the verdict.
// Depends on cbt_pkg, the channel interfaces, cbt_checker and the block itself.
module cubic_bezier_tessellator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cbt_pkg::*;

   // index past the register list, must be ignored by the block
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 4'd9;
   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;
   localparam coord_type COORD_ONE = 32'sh0001_0000;
   // first curve point trails the closing control point via a two-segment queue
   // and three de Casteljau levels; this covers segments that emit nothing
   localparam int DRAIN_CYCLES  = 24;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_POINTS  = 40;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   points_pending;
   bit   gaps_on;
   int   burst_left;

   cbt_req_if req_ch ();
   cbt_rsp_if rsp_ch ();
   cbt_csr_if csr_ch ();

   cubic_bezier_tessellator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cbt_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .points_pending (points_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly extremes and small values, the rest full-range random so every
   // coordinate bit toggles.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3: return -1;
         4, 5: return coord_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return $urandom;
      endcase
   endfunction

   // One register beat; valid drops in the step the beat is taken and stays
   // low until the next beat.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Both registers in random order, now and then a write to an unused index.
   task automatic write_setting(logic [STEPS_CFG_W-1:0] steps, logic [TINC_W-1:0] tinc);
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_SPARE_IDX, CSR_DATA_W'($urandom));
      end
      if ($urandom_range(0, 1) == 0) begin
         write_reg(CSR_STEPS_IDX, CSR_DATA_W'(steps));
         write_reg(CSR_TINC_IDX, tinc);
      end else begin
         write_reg(CSR_TINC_IDX, tinc);
         write_reg(CSR_STEPS_IDX, CSR_DATA_W'(steps));
      end
   endtask

   // One control point beat. With gaps on, beats go out in bursts; valid is
   // only lowered when a gap follows, so back-to-back beats keep it high.
   task automatic send_point(coord_type x, coord_type y, coord_type z, logic start);
      if (gaps_on && burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_ch.valid       <= 1'b1;
      req_ch.ctrl_x      <= x;
      req_ch.ctrl_y      <= y;
      req_ch.ctrl_z      <= z;
      req_ch.start_curve <= start;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop sending and wait until every predicted curve point has come back,
   // then give a segment with no output time to leave the pipeline.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (points_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Receiver back-pressure: stretches of always-ready, light stalls and
   // heavy stalls, with the mode drawn at random for each stretch.
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 120)) begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [STEPS_CFG_W-1:0] steps;
      logic [TINC_W-1:0]      tinc;
      int                     pause_at;
      int                     start_odds;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.ctrl_x      <= '0;
      req_ch.ctrl_y      <= '0;
      req_ch.ctrl_z      <= '0;
      req_ch.start_curve <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= '0;
      csr_ch.data        <= '0;
      gaps_on    = 1'b0;
      burst_left = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part, reset setting: 16 points, dt = 1/16 ---
      // first segment from coordinate extremes
      send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
      send_point(COORD_MIN, COORD_MAX, -1, 1'b0);
      send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
      // follow-on segment shares the previous end point
      send_point('0, COORD_ONE, -1, 1'b0);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      send_point(COORD_MIN, '0, COORD_MIN, 1'b0);
      // new curve started mid-segment: the partial points are dropped
      send_point(COORD_ONE, -COORD_ONE, COORD_ONE, 1'b1);
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
      send_point(-COORD_ONE, COORD_ONE, '0, 1'b1);
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);

      // zero steps: segment completes silently, end point still carried over
      settle();
      write_setting(7'd0, TINC_RESET);
      repeat (3) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);

      // step count above the maximum is clamped
      settle();
      write_setting('1, 16'd1024);
      repeat (3) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);

      // t runs past one and pins at the segment end point
      settle();
      write_setting(7'd64, '1);
      repeat (3) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);

      // zero increment: every point is the segment start point
      settle();
      write_setting(7'd5, '0);
      repeat (2) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);

      // write to an unused index must leave the setting alone
      settle();
      write_reg(CSR_SPARE_IDX, '1);
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);

      // --- random part: one setting per phase, small step counts favored ---
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 9))
            0: steps = '0;
            1: steps = '1;
            2: steps = 7'd64;
            3: steps = 7'd1;
            default: steps = STEPS_CFG_W'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 7))
            0: tinc = '0;
            1: tinc = 16'd1;
            2: tinc = '1;
            3: tinc = TINC_W'($urandom);
            default: tinc = (steps > 1) ? TINC_W'(T_ONE / (steps - 1)) : TINC_W'($urandom);
         endcase
         settle();
         write_setting(steps, tinc);

         gaps_on    = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         // most phases are long curves; some are noise with frequent restarts
         start_odds = ($urandom_range(0, 4) == 0) ? 2 : 12;
         pause_at   = $urandom_range(0, PHASE_POINTS - 1);
         for (int i = 0; i < PHASE_POINTS; i++) begin
            if (i == pause_at) begin
               settle();
            end
            send_point(rand_coord(), rand_coord(), rand_coord(),
                       $urandom_range(1, start_odds) == 1);
         end
      end

      settle();
      if (mismatch_count == 0 && points_pending == 0) begin
         $display("cubic_bezier_tessellator_test passed");
      end else begin
         $display("cubic_bezier_tessellator_test failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("cubic_bezier_tessellator_test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/cbt_pkg.sv
src/cbt_req_if.sv
src/cbt_rsp_if.sv
src/cbt_csr_if.sv
src/cbt_front.sv
src/cbt_seg_queue.sv
src/cbt_eval.sv
src/cubic_bezier_tessellator.sv
dv/cbt_checker.sv
dv/cubic_bezier_tessellator_test.sv
